### src/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

   localparam int PIX_W        = 8;
   localparam int MAG_W        = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int GRAD_W       = 11;
   localparam int SQ_W         = 21;
   localparam int ROOT_IN_W    = 16;
   localparam int MIN_DIM      = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [MAG_W-1:0] MAG_CLAMP = 8'd255;

   // per-word position info worked out by the front end
   typedef struct packed {
      logic emit;
      logic row_top;
      logic row_bottom;
      logic col_left;
      logic col_right;
      logic last;
   } item_flags_type;

   localparam int FLAGS_W = $bits(item_flags_type);

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_GRAD,
      BK_SQUARE,
      BK_ROOT,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

### src/sem_req_if.sv
// Input channel: valid/ready handshake carrying one pixel or drain word.
`default_nettype none

interface sem_req_if import sem_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output operation, output pixel_value, input ready);
   modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

`default_nettype wire

### src/sem_rsp_if.sv
// Result channel: valid/ready handshake carrying one gradient magnitude.
`default_nettype none

interface sem_rsp_if import sem_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic             last_pixel;

   modport source (output valid, output magnitude, output last_pixel, input ready);
   modport sink   (input valid, input magnitude, input last_pixel, output ready);
endinterface

`default_nettype wire

### src/sem_front.sv
// Front end: config registers, raster position tracking and word classification.
`default_nettype none

module sem_front import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   localparam int COL_W   = $clog2(MAX_WIDTH),
   localparam int ENTRY_W = COL_W + PIX_W + FLAGS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   sem_req_if.sink                req_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [ENTRY_W-1:0]     q_push_data
);

   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);   // row runs to height+1 while draining

   function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] v);
      logic [WID_W-1:0] r;
      if (32'(v) < 32'(MIN_DIM)) begin
         r = WID_W'(MIN_DIM);
      end else if (32'(v) > 32'(MAX_WIDTH)) begin
         r = WID_W'(MAX_WIDTH);
      end else begin
         r = WID_W'(v);
      end
      return r;
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] v);
      logic [HGT_W-1:0] r;
      if (32'(v) < 32'(MIN_DIM)) begin
         r = HGT_W'(MIN_DIM);
      end else if (32'(v) > 32'(MAX_HEIGHT)) begin
         r = HGT_W'(MAX_HEIGHT);
      end else begin
         r = HGT_W'(v);
      end
      return r;
   endfunction

   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             accept;
   logic             in_image;
   logic             ignore;
   logic             first_col;
   logic [ROW_W-1:0] h_ext;
   logic [ROW_W-1:0] h_last;
   logic [COL_W-1:0] w_last;
   logic [COL_W-1:0] cx;
   logic [ROW_W-1:0] cy;
   logic             emit_pos;
   logic [PIX_W-1:0] pix;
   item_flags_type   flags;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      h_ext     = ROW_W'(height_ff);
      h_last    = h_ext - 1'b1;
      w_last    = COL_W'(width_ff - 1'b1);
      first_col = (col_ff == '0);
      in_image  = (row_ff < h_ext);
      ignore    = in_image && (req_chan.operation == OP_DRAIN);
      pix       = in_image ? req_chan.pixel_value : '0;

      // window center trails the input by one row and one column
      if (first_col) begin
         cx       = w_last;
         cy       = row_ff - ROW_W'(2);
         emit_pos = (row_ff >= ROW_W'(2));
      end else begin
         cx       = col_ff - 1'b1;
         cy       = row_ff - 1'b1;
         emit_pos = (row_ff != '0);
      end

      flags.emit       = emit_pos && (cy < h_ext);
      flags.row_top    = (cy != '0);
      flags.row_bottom = (cy != h_last);
      flags.col_left   = (cx != '0);
      flags.col_right  = (cx != w_last);
      flags.last       = flags.emit && (cy == h_last) && (cx == w_last);

      q_push      = accept && !ignore;
      q_push_data = {col_ff, pix, flags};

      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (q_push) begin
         if (flags.last) begin
            col_in = '0;
            row_in = '0;
         end else if ((WID_W'(col_ff) + 1'b1) == width_ff) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_width(RESET_IMAGE_WIDTH);
         height_ff <= clamp_height(RESET_IMAGE_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= clamp_width(csr_wdata[CFG_WIDTH_W-1:0]);
               CSR_IMAGE_HEIGHT: height_ff <= clamp_height(csr_wdata[CFG_HEIGHT_W-1:0]);
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### src/sem_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module sem_queue import sem_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### src/sem_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module sem_sqrt import sem_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ROOT_IN_W-1:0] operand,
   output logic                 busy,
   output logic                 done,
   output logic [MAG_W-1:0]     root
);

   localparam int REM_W  = MAG_W + 2;
   localparam int STEP_W = $clog2(MAG_W);

   logic [REM_W-1:0]     rem_ff;
   logic [MAG_W-1:0]     root_ff;
   logic [ROOT_IN_W-1:0] radicand_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic             fits;

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

   // partial remainder never exceeds twice the partial root, so its low bits suffice
   always_comb begin
      rem_shift = {rem_ff[MAG_W-1:0], radicand_ff[ROOT_IN_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      fits      = (rem_shift >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff      <= '0;
         root_ff     <= '0;
         radicand_ff <= operand;
         step_ff     <= STEP_W'(MAG_W - 1);
      end else if (busy_ff) begin
         rem_ff      <= fits ? (rem_shift - trial) : rem_shift;
         root_ff     <= {root_ff[MAG_W-2:0], fits};
         radicand_ff <= {radicand_ff[ROOT_IN_W-3:0], 2'b00};
         step_ff     <= step_ff - 1'b1;
      end
   end

endmodule

`default_nettype wire

### src/sem_back.sv
// Back end: line store, 3x3 window, Sobel gradients, magnitude and result register.
`default_nettype none

module sem_back import sem_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int COL_W   = $clog2(MAX_WIDTH),
   localparam int ENTRY_W = COL_W + PIX_W + FLAGS_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic               q_valid,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               q_pop,
   sem_rsp_if.source          rsp_chan
);

   // upper line in the high byte, middle line in the low byte
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   back_state_type state_ff, state_in;

   logic [COL_W-1:0] cur_addr_ff;
   logic [PIX_W-1:0] cur_pix_ff;
   item_flags_type   cur_flags_ff;

   logic [2:0][2:0][PIX_W-1:0] win_ff;
   logic signed [GRAD_W-1:0]   gx_ff, gy_ff;
   logic                       sat_ff;

   logic             rsp_valid_ff;
   logic [MAG_W-1:0] rsp_magnitude_ff;
   logic             rsp_last_ff;

   logic mem_wr;
   logic sqrt_start;
   logic sqrt_busy;
   logic sqrt_done;
   logic out_load;
   logic [MAG_W-1:0] sqrt_root;

   logic [2:0][2:0][PIX_W-1:0] masked;
   logic [2:0]                 row_ok;
   logic [2:0]                 col_ok;
   logic [PIX_W+1:0]           gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0]   gx_in, gy_in;
   logic signed [2*GRAD_W-1:0] sq_x, sq_y;
   logic [SQ_W-1:0]            sq_sum;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.magnitude  = rsp_magnitude_ff;
   assign rsp_chan.last_pixel = rsp_last_ff;

   always_comb begin
      state_in   = state_ff;
      q_pop      = 1'b0;
      mem_wr     = 1'b0;
      sqrt_start = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            mem_wr   = 1'b1;
            state_in = cur_flags_ff.emit ? BK_GRAD : BK_IDLE;
         end
         BK_GRAD: begin
            state_in = BK_SQUARE;
         end
         BK_SQUARE: begin
            sqrt_start = 1'b1;
            state_in   = BK_ROOT;
         end
         BK_ROOT: begin
            if (sqrt_done) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff   <= line_mem[q_data[ENTRY_W-1 -: COL_W]];
         cur_addr_ff  <= q_data[ENTRY_W-1 -: COL_W];
         cur_pix_ff   <= q_data[FLAGS_W +: PIX_W];
         cur_flags_ff <= item_flags_type'(q_data[FLAGS_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[cur_addr_ff] <= {rd_data_ff[PIX_W-1:0], cur_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         win_ff <= '0;
      end else if (state_ff == BK_LOAD) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_data_ff[2*PIX_W-1:PIX_W];
         win_ff[1][2] <= rd_data_ff[PIX_W-1:0];
         win_ff[2][2] <= cur_pix_ff;
      end else if ((state_ff == BK_SQUARE) && cur_flags_ff.last) begin
         win_ff <= '0;   // end of image: next image starts from a zero window
      end
   end

   // taps outside the image read as zero
   always_comb begin
      row_ok = {cur_flags_ff.row_bottom, 1'b1, cur_flags_ff.row_top};
      col_ok = {cur_flags_ff.col_right, 1'b1, cur_flags_ff.col_left};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            masked[r][c] = (row_ok[r] && col_ok[c]) ? win_ff[r][c] : '0;
         end
      end
      gx_pos = (PIX_W+2)'(masked[0][2]) + (PIX_W+2)'({masked[1][2], 1'b0})
             + (PIX_W+2)'(masked[2][2]);
      gx_neg = (PIX_W+2)'(masked[0][0]) + (PIX_W+2)'({masked[1][0], 1'b0})
             + (PIX_W+2)'(masked[2][0]);
      gy_pos = (PIX_W+2)'(masked[2][0]) + (PIX_W+2)'({masked[2][1], 1'b0})
             + (PIX_W+2)'(masked[2][2]);
      gy_neg = (PIX_W+2)'(masked[0][0]) + (PIX_W+2)'({masked[0][1], 1'b0})
             + (PIX_W+2)'(masked[0][2]);
      gx_in  = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy_in  = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

      sq_x   = gx_ff * gx_ff;
      sq_y   = gy_ff * gy_ff;
      sq_sum = SQ_W'(sq_x[SQ_W-2:0]) + SQ_W'(sq_y[SQ_W-2:0]);
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_GRAD) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (sqrt_start) begin
         sat_ff <= |sq_sum[SQ_W-1:ROOT_IN_W];
      end
   end

   sem_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sq_sum[ROOT_IN_W-1:0]),
      .busy    (sqrt_busy),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_magnitude_ff <= sat_ff ? MAG_CLAMP : sqrt_root;
         rsp_last_ff      <= cur_flags_ff.last;
      end
   end

   a_sqrt_start_free: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_busy)
      else $error("square root started while still busy");

   a_out_reg_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result register overwritten before it was taken");

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == BK_SQUARE) && cur_flags_ff.last) |=> (win_ff == '0))
      else $error("window not cleared after last pixel of image");

endmodule

`default_nettype wire

### src/sobel_edge_magnitude.sv
// Top level: streaming 3x3 Sobel gradient magnitude over a raster image.
//
//  Port group   Dir   Contents
//  req_chan     in    operation (pixel / drain), pixel_value[7:0]
//  rsp_chan     out   magnitude[7:0], last_pixel
//  csr_*        in    csr_we, csr_index (0 width, 1 height), csr_wdata[12:0]
//
//  A word that yields no result passes only the back end's idle and load states;
//  one that yields a result goes through line store read, window update, gradient,
//  squares and the bit-serial square root, which sets the rate.
//  The front end classifies a word in the cycle it is accepted and queues it
//  (2 entries). Input keeps flowing for two words while the back end or rsp_chan
//  stalls, then req_chan.ready drops. Drain words inside the image end in the front.
//  Synchronous reset clears control state; line store contents start undefined.
//  A config write restarts the image.
`default_nettype none

module sobel_edge_magnitude import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   sem_req_if.sink                req_chan,
   sem_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ENTRY_W = $clog2(MAX_WIDTH) + PIX_W + FLAGS_W;

   logic               q_push;
   logic [ENTRY_W-1:0] q_push_data;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   logic [ENTRY_W-1:0] q_head;

   sem_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   sem_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_data (q_head)
   );

   sem_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_we),
      .q_valid  (q_valid),
      .q_data   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
